// ----- sv/obi_pkg.sv -----
// ----------------------------------------------------------------------------
// obi_pkg
// shared types and constants for the octree box insert block
// ----------------------------------------------------------------------------
package obi_pkg;
  localparam int NodeSlots  = 256;
  localparam int EntrySlots = 1024;
  localparam int NodeW      = $clog2(NodeSlots);
  localparam int EntryW     = $clog2(EntrySlots);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROOT, ST_READ, ST_DECIDE, ST_LINK, ST_ALLOC, ST_APPEND, ST_DONE,
    ST_WIPE
  } obi_state_t;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0, STAT_NODE_FULL = 2'd1, STAT_ENTRY_FULL = 2'd2
  } obi_status_t;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_HLF_X = 3'd3;
  localparam logic [2:0] REG_HLF_Y = 3'd4;
  localparam logic [2:0] REG_HLF_Z = 3'd5;
  localparam logic [2:0] REG_DEPTH = 3'd6;

  // node geometry record: centres (33 bit signed) and halves (31 bit)
  typedef struct packed {
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [32:0] cz;
    logic [30:0] hx;
    logic [30:0] hy;
    logic [30:0] hz;
  } obi_geom_t;
endpackage

// ----- sv/obi_node_mem.sv -----
// ----------------------------------------------------------------------------
// obi_node_mem
// node store: geometry and child links, with registered read ports adding latency
// ----------------------------------------------------------------------------
module obi_node_mem (
  input  logic                      clk,
  input  logic                      geom_we,
  input  logic [obi_pkg::NodeW-1:0] geom_waddr,
  input  obi_pkg::obi_geom_t        geom_wdata,
  input  logic [obi_pkg::NodeW-1:0] geom_raddr,
  output obi_pkg::obi_geom_t        geom_rdata,
  input  logic                      link_we,
  input  logic [obi_pkg::NodeW+2:0] link_waddr,
  input  logic [obi_pkg::NodeW-1:0] link_wdata,
  input  logic [obi_pkg::NodeW+2:0] link_raddr,
  output logic [obi_pkg::NodeW-1:0] link_rdata
);
  import obi_pkg::*;

  obi_geom_t        geom_mem [NodeSlots];
  logic [NodeW-1:0] link_mem [NodeSlots*8];

  always_ff @(posedge clk) begin
    if (geom_we) begin
      geom_mem[geom_waddr] <= geom_wdata;
    end
    geom_rdata <= geom_mem[geom_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end
endmodule

// ----- sv/octree_box_insert.sv -----
// ----------------------------------------------------------------------------
// octree_box_insert
// fixed-point octree insertion of axis-aligned boxes
// ----------------------------------------------------------------------------
// One request at a time. A clear rebuilds the root and finishes. An insert
// builds the root if there is none, stops if the entry pool is full, else
// per level descended through an existing child reads node memory, compares
// octants and reads the child link, with an allocation step added for a level
// that allocates a child, and then appends the entry.
// Child links and list counts are qualified by a clear epoch, so a clear needs
// no clearing pass; the epoch marks are wiped after reset and again whenever
// the 8-bit epoch wraps, at a tree rebuild that finds it at 255. Entry boxes and tags
// are stored in entry memory; lists are chained through a next-entry memory.
module octree_box_insert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  input  logic [15:0] in_object_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_target_node,
  output logic [9:0]  out_entry_index,
  output logic [8:0]  out_nodes_in_use
);
  import obi_pkg::*;

  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [30:0] hlf_x_r, hlf_y_r, hlf_z_r;
  logic [3:0]  depth_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      hlf_x_r <= 31'd65536; hlf_y_r <= 31'd65536; hlf_z_r <= 31'd65536;
      depth_r <= 4'd8;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORG_X: org_x_r <= cfg_pwdata;
        REG_ORG_Y: org_y_r <= cfg_pwdata;
        REG_ORG_Z: org_z_r <= cfg_pwdata;
        REG_HLF_X: hlf_x_r <= cfg_pwdata[30:0];
        REG_HLF_Y: hlf_y_r <= cfg_pwdata[30:0];
        REG_HLF_Z: hlf_z_r <= cfg_pwdata[30:0];
        REG_DEPTH: depth_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORG_X: cfg_prdata = org_x_r;
      REG_ORG_Y: cfg_prdata = org_y_r;
      REG_ORG_Z: cfg_prdata = org_z_r;
      REG_HLF_X: cfg_prdata = {1'b0, hlf_x_r};
      REG_HLF_Y: cfg_prdata = {1'b0, hlf_y_r};
      REG_HLF_Z: cfg_prdata = {1'b0, hlf_z_r};
      REG_DEPTH: cfg_prdata = {28'd0, depth_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------- state
  obi_state_t st_r, st_nxt;
  logic [NodeW:0]    nfill_r;
  logic [EntryW:0]   efill_r;
  logic [NodeW-1:0]  node_r;
  logic [2:0]        oct_r;
  logic [3:0]        lvl_r;
  logic [1:0]        stat_r;
  logic              cmd_r;
  logic [15:0]       tag_r;
  logic signed [32:0] mnx_r, mny_r, mnz_r, mxx_r, mxy_r, mxz_r;
  obi_geom_t         pgeom_r;
  logic [NodeW+2:0]  wipe_r;

  // node memory signals
  logic              geom_we, link_we;
  logic [NodeW-1:0]  geom_waddr, geom_raddr, link_wdata, link_rdata;
  logic [NodeW+2:0]  link_waddr, link_raddr;
  obi_geom_t         geom_wdata, geom_rdata;

  obi_node_mem u_node_mem (
    .clk, .geom_we, .geom_waddr, .geom_wdata, .geom_raddr, .geom_rdata,
    .link_we, .link_waddr, .link_wdata, .link_raddr, .link_rdata
  );

  // list heads/tails/counts per node, and entry memories
  logic [EntryW-1:0] tail_mem [NodeSlots];
  logic [EntryW:0]   cnt_mem  [NodeSlots];
  logic [EntryW-1:0] next_mem [EntrySlots];
  logic [EntryW-1:0] head_mem [NodeSlots];
  logic [197:0]      box_mem  [EntrySlots];
  logic [15:0]       tag_mem  [EntrySlots];
  logic [EntryW-1:0] tail_rd_r;
  logic [EntryW:0]   cnt_rd_r;
  logic [NodeW:0]    lgen_mem [NodeSlots*8];
  logic [NodeW:0]    lgen_rd_r;

  // node child link validity: link stores child index; child valid when the
  // link was written since the last clear, tracked via clear epoch counter
  logic [7:0]        epoch_r;
  logic [7:0]        lep_mem [NodeSlots*8];
  logic [7:0]        lep_rd_r;
  logic [7:0]        cep_mem [NodeSlots];
  logic [7:0]        cep_rd_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // octant compare on geometry read
  logic [2:0] oct_c;
  logic       strad_c;
  always_comb begin
    oct_c   = '0;
    strad_c = 1'b0;
    if (mnx_r >= geom_rdata.cx) oct_c[2] = 1'b1;
    else if (mxx_r >= geom_rdata.cx) strad_c = 1'b1;
    if (mny_r >= geom_rdata.cy) oct_c[1] = 1'b1;
    else if (mxy_r >= geom_rdata.cy) strad_c = 1'b1;
    if (mnz_r >= geom_rdata.cz) oct_c[0] = 1'b1;
    else if (mxz_r >= geom_rdata.cz) strad_c = 1'b1;
  end

  logic link_ok;
  assign link_ok = (lep_rd_r == epoch_r) && (lgen_rd_r != '0);
  logic cnt_ok;
  assign cnt_ok = (cep_rd_r == epoch_r) && (cnt_rd_r != '0);

  logic root_needed;
  assign root_needed = !cmd_r || (nfill_r == '0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_needed && epoch_r == '1) st_nxt = ST_WIPE;
        else if (!cmd_r) st_nxt = ST_DONE;
        else if (efill_r >= (EntryW+1)'(EntrySlots)) st_nxt = ST_DONE;
        else st_nxt = ST_READ;
      end
      ST_READ:   st_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (lvl_r >= depth_r || strad_c) st_nxt = ST_APPEND;
        else st_nxt = ST_LINK;
      end
      ST_LINK: begin
        if (link_ok) st_nxt = ST_READ;
        else if (nfill_r >= (NodeW+1)'(NodeSlots)) st_nxt = ST_APPEND;
        else st_nxt = ST_ALLOC;
      end
      ST_ALLOC:  st_nxt = ST_READ;
      ST_APPEND: st_nxt = ST_DONE;
      ST_DONE:   if (out_acc) st_nxt = ST_IDLE;
      ST_WIPE: begin
        if (wipe_r == '1) st_nxt = (nfill_r == '0) ? ST_IDLE : ST_ROOT;
      end
      default:   st_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_DONE);

  // child geometry
  obi_geom_t child_g;
  always_comb begin
    child_g.hx = pgeom_r.hx >> 1;
    child_g.hy = pgeom_r.hy >> 1;
    child_g.hz = pgeom_r.hz >> 1;
    child_g.cx = oct_r[2] ? pgeom_r.cx + $signed({2'b0, child_g.hx})
                          : pgeom_r.cx - $signed({2'b0, child_g.hx});
    child_g.cy = oct_r[1] ? pgeom_r.cy + $signed({2'b0, child_g.hy})
                          : pgeom_r.cy - $signed({2'b0, child_g.hy});
    child_g.cz = oct_r[0] ? pgeom_r.cz + $signed({2'b0, child_g.hz})
                          : pgeom_r.cz - $signed({2'b0, child_g.hz});
  end

  always_comb begin
    geom_we    = 1'b0;
    geom_waddr = node_r;
    geom_wdata = child_g;
    geom_raddr = node_r;
    link_we    = 1'b0;
    link_waddr = {node_r, oct_r};
    link_wdata = nfill_r[NodeW-1:0];
    link_raddr = {node_r, oct_c};
    case (st_r)
      ST_ROOT: begin
        geom_we    = root_needed;
        geom_waddr = '0;
        geom_wdata = '{cx: '0, cy: '0, cz: '0, hx: hlf_x_r, hy: hlf_y_r, hz: hlf_z_r};
      end
      ST_ALLOC: begin
        geom_we    = 1'b1;
        geom_waddr = nfill_r[NodeW-1:0];
        link_we    = 1'b1;
      end
      default: ;
    endcase
  end

  // sign-extended relative corners
  logic signed [32:0] rmnx, rmny, rmnz, rmxx, rmxy, rmxz;
  assign rmnx = 33'(in_box_min_x) - 33'(org_x_r);
  assign rmny = 33'(in_box_min_y) - 33'(org_y_r);
  assign rmnz = 33'(in_box_min_z) - 33'(org_z_r);
  assign rmxx = 33'(in_box_max_x) - 33'(org_x_r);
  assign rmxy = 33'(in_box_max_y) - 33'(org_y_r);
  assign rmxz = 33'(in_box_max_z) - 33'(org_z_r);

  // link metadata memories (epoch, nonzero mark); the epoch one is wiped one entry a cycle
  always_ff @(posedge clk) begin
    if (st_r == ST_WIPE) begin
      lep_mem[wipe_r] <= '0;
    end else if (st_r == ST_ALLOC) begin
      lep_mem[{node_r, oct_r}]  <= epoch_r;
      lgen_mem[{node_r, oct_r}] <= nfill_r;
    end
    lep_rd_r  <= lep_mem[link_raddr];
    lgen_rd_r <= lgen_mem[link_raddr];
  end

  // list memories
  logic ap_we;
  logic [EntryW-1:0] e_idx, e_last;
  assign ap_we  = (st_r == ST_APPEND);
  assign e_idx  = efill_r[EntryW-1:0];
  assign e_last = efill_r[EntryW-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    if (ap_we) begin
      tail_mem[node_r] <= e_idx;
      cnt_mem[node_r]  <= cnt_ok ? cnt_rd_r + 1'b1 : (EntryW+1)'(1);
      cep_mem[node_r]  <= epoch_r;
      if (!cnt_ok) head_mem[node_r] <= e_idx;
    end else if (st_r == ST_WIPE) begin
      cep_mem[wipe_r[NodeW-1:0]] <= '0;
    end
    tail_rd_r <= tail_mem[node_r];
    cnt_rd_r  <= cnt_mem[node_r];
    cep_rd_r  <= cep_mem[node_r];
  end

  function automatic logic [32:0] half_floor(input logic signed [33:0] v);
    return v[33:1];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'h7fffffff;
    else if (v < -33'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction

  logic [197:0] box_w;
  always_comb begin
    box_w[31:0]    = sat32(half_floor(34'(mnx_r) + 34'(mxx_r)));
    box_w[63:32]   = sat32(half_floor(34'(mny_r) + 34'(mxy_r)));
    box_w[95:64]   = sat32(half_floor(34'(mnz_r) + 34'(mxz_r)));
    box_w[127:96]  = sat32(half_floor(34'(mxx_r) - 34'(mnx_r)));
    box_w[159:128] = sat32(half_floor(34'(mxy_r) - 34'(mny_r)));
    box_w[191:160] = sat32(half_floor(34'(mxz_r) - 34'(mnz_r)));
    box_w[197:192] = '0;
  end

  // chain onto the old tail while appending, terminate the new entry after
  always_ff @(posedge clk) begin
    if (ap_we) begin
      box_mem[e_idx] <= box_w;
      tag_mem[e_idx] <= tag_r;
      if (cnt_ok) next_mem[tail_rd_r] <= e_idx;
    end else if (st_r == ST_DONE && cmd_r && stat_r != STAT_ENTRY_FULL) begin
      next_mem[e_last] <= '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_WIPE;
      nfill_r <= '0;
      efill_r <= '0;
      epoch_r <= '0;
      wipe_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_ROOT && root_needed) begin
        nfill_r <= (NodeW+1)'(1);
        efill_r <= '0;
        epoch_r <= epoch_r + 1'b1;
      end
      if (st_r == ST_ALLOC) nfill_r <= nfill_r + 1'b1;
      if (ap_we) efill_r <= efill_r + 1'b1;
      if (st_r == ST_WIPE) wipe_r <= wipe_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd;
      tag_r <= in_object_tag;
      mnx_r <= rmnx; mny_r <= rmny; mnz_r <= rmnz;
      mxx_r <= rmxx; mxy_r <= rmxy; mxz_r <= rmxz;
      node_r <= '0;
      lvl_r  <= '0;
      stat_r <= STAT_OK;
    end
    case (st_r)
      ST_ROOT: begin
        if (cmd_r && efill_r >= (EntryW+1)'(EntrySlots)) stat_r <= STAT_ENTRY_FULL;
      end
      ST_DECIDE: begin
        pgeom_r <= geom_rdata;
        oct_r   <= oct_c;
      end
      ST_LINK: begin
        lvl_r <= lvl_r + 1'b1;
        if (link_ok) node_r <= link_rdata;
        else if (nfill_r >= (NodeW+1)'(NodeSlots)) stat_r <= STAT_NODE_FULL;
      end
      ST_ALLOC: node_r <= nfill_r[NodeW-1:0];
      default: ;
    endcase
  end

  assign out_status       = stat_r;
  assign out_target_node  = (stat_r == STAT_ENTRY_FULL || !cmd_r) ? 8'd0 : node_r;
  assign out_entry_index  = (stat_r == STAT_ENTRY_FULL || !cmd_r) ? 10'd0
                                                                   : efill_r[9:0] - 10'd1;
  assign out_nodes_in_use = nfill_r;

  // a descended node index never reaches the fill count
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DECIDE |-> {1'b0, node_r} < nfill_r)
    else $error("node index beyond fill");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ALLOC |-> nfill_r < (NodeW+1)'(NodeSlots))
    else $error("allocation from a full node pool");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_APPEND |-> efill_r < (EntryW+1)'(EntrySlots))
    else $error("append to a full entry pool");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DONE && cmd_r |-> nfill_r != '0)
    else $error("insert finished without a root");
endmodule

// ----- verif/tb_octree_box_insert.sv -----
// ----------------------------------------------------------------------------
// tb_octree_box_insert
// self-checking testbench for the octree box insert block: a scoreboard keeps
// its own copy of the tree (child links, node centres and halves, pool fills)
// and predicts every response; directed corner cases come first, then random
// boxes under several register settings and idle patterns
// ----------------------------------------------------------------------------
module tb_octree_box_insert;
  timeunit 1ns;
  timeprecision 1ps;
  import obi_pkg::*;

  typedef struct {
    obi_status_t status;
    bit [7:0]    node;
    bit [9:0]    entry;
    bit [8:0]    nodes;
  } insert_result_t;

  class insert_scoreboard;
    longint      org[3];
    int unsigned rhalf[3];
    int unsigned depth;
    bit [8:0]    links[NodeSlots*8];
    longint      cen[NodeSlots*3];
    int unsigned hlf[NodeSlots*3];
    int unsigned nfill, efill;
    insert_result_t pending[$];

    function new();
      for (int a = 0; a < 3; a++) begin
        org[a] = 0;
        rhalf[a] = 65536;
      end
      depth = 8;
      nfill = 0;
      efill = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] v);
      case (idx)
        REG_ORG_X, REG_ORG_Y, REG_ORG_Z: org[idx] = longint'($signed(v));
        REG_HLF_X, REG_HLF_Y, REG_HLF_Z: rhalf[idx - REG_HLF_X] = v & 32'h7fffffff;
        REG_DEPTH: depth = v & 32'hf;
        default: ;
      endcase
    endfunction

    function void build_root();
      nfill = 1;
      efill = 0;
      for (int k = 0; k < 8; k++) links[k] = 0;
      for (int a = 0; a < 3; a++) begin
        cen[a] = 0;
        hlf[a] = rhalf[a];
      end
    endfunction

    function void note_request(bit cmd, bit [31:0] bmin[3], bit [31:0] bmax[3]);
      insert_result_t r;
      longint mn[3], mx[3], c;
      int unsigned node, oct, n;
      bit straddle;
      r.status = STAT_OK;
      r.node = 0;
      r.entry = 0;
      if (!cmd) begin
        build_root();
        r.nodes = 1;
        pending.push_back(r);
        return;
      end
      if (nfill == 0) build_root();
      if (efill >= EntrySlots) begin
        r.status = STAT_ENTRY_FULL;
        r.nodes = 9'(nfill);
        pending.push_back(r);
        return;
      end
      for (int a = 0; a < 3; a++) begin
        mn[a] = longint'($signed(bmin[a])) - org[a];
        mx[a] = longint'($signed(bmax[a])) - org[a];
      end
      node = 0;
      for (int d = 0; d < depth; d++) begin
        oct = 0;
        straddle = 0;
        for (int a = 0; a < 3; a++) begin
          c = cen[node*3 + a];
          if (mn[a] >= c) oct |= 4 >> a;
          else if (mx[a] >= c) straddle = 1;
        end
        if (straddle) break;
        if (links[node*8 + oct] != 0) begin
          node = links[node*8 + oct];
          continue;
        end
        if (nfill >= NodeSlots) begin
          r.status = STAT_NODE_FULL;
          break;
        end
        n = nfill++;
        for (int k = 0; k < 8; k++) links[n*8 + k] = 0;
        links[node*8 + oct] = 9'(n);
        for (int a = 0; a < 3; a++) begin
          hlf[n*3 + a] = hlf[node*3 + a] >> 1;
          cen[n*3 + a] = (oct & (4 >> a)) ? cen[node*3 + a] + hlf[n*3 + a]
                                          : cen[node*3 + a] - hlf[n*3 + a];
        end
        node = n;
      end
      r.node = 8'(node);
      r.entry = 10'(efill);
      efill++;
      r.nodes = 9'(nfill);
      pending.push_back(r);
    endfunction

    // flags: 4 nothing pending, 3 status, 2 node, 1 entry, 0 node count
    function bit [4:0] check_result(bit [1:0] st, bit [7:0] tn, bit [9:0] ei, bit [8:0] nu);
      insert_result_t r;
      if (pending.size() == 0) return 5'b10000;
      r = pending.pop_front();
      return {1'b0, st != r.status, tn != r.node, ei != r.entry, nu != r.nodes};
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic in_valid, in_ready, in_cmd, out_valid, out_ready;
  logic signed [31:0] pmin[3], pmax[3];
  logic [15:0] in_object_tag;
  logic [1:0] out_status;
  logic [7:0] out_target_node;
  logic [9:0] out_entry_index;
  logic [8:0] out_nodes_in_use;

  octree_box_insert dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_box_min_x(pmin[0]), .in_box_min_y(pmin[1]), .in_box_min_z(pmin[2]),
    .in_box_max_x(pmax[0]), .in_box_max_y(pmax[1]), .in_box_max_z(pmax[2]),
    .in_object_tag(in_object_tag),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_target_node(out_target_node), .out_entry_index(out_entry_index),
    .out_nodes_in_use(out_nodes_in_use)
  );

  insert_scoreboard sb = new();
  int unsigned errors = 0;
  int unsigned tx_idle = 27, rx_idle = 79;
  int unsigned sent = 0;
  int unsigned quiet = 0;
  int unsigned hold_left = 0;
  bit held = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    in_valid = 0;
    in_cmd = 0;
    in_object_tag = 0;
    out_ready = 0;
    for (int a = 0; a < 3; a++) begin
      pmin[a] = 0;
      pmax[a] = 0;
    end
  end

  task automatic report(string what, bit [4:0] flags);
    errors++;
    $display("mismatch %s flags %b status %0d node %0d entry %0d nodes %0d",
             what, flags, out_status, out_target_node, out_entry_index, out_nodes_in_use);
  endtask

  always @(posedge clk) begin
    bit [4:0] f;
    bit [31:0] mn[3], mx[3];
    if (rst_n) begin
      if (out_valid && out_ready) begin
        f = sb.check_result(out_status, out_target_node, out_entry_index, out_nodes_in_use);
        if (f[4]) report("unexpected response", f);
        else if (f != 0) report("response field", f);
      end
      if (in_valid && in_ready) begin
        for (int a = 0; a < 3; a++) begin
          mn[a] = pmin[a];
          mx[a] = pmax[a];
        end
        sb.note_request(in_cmd, mn, mx);
        sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
        $display("tb_octree_box_insert failed");
        $finish;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (!held && sent >= 200) begin
      held <= 1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic reg_write(logic [2:0] idx, bit [31:0] v);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(bit [31:0] ox, bit [31:0] oy, bit [31:0] oz,
                           bit [31:0] hx, bit [31:0] hy, bit [31:0] hz, bit [31:0] dep);
    drain();
    reg_write(REG_ORG_X, ox);
    reg_write(REG_ORG_Y, oy);
    reg_write(REG_ORG_Z, oz);
    reg_write(REG_HLF_X, hx);
    reg_write(REG_HLF_Y, hy);
    reg_write(REG_HLF_Z, hz);
    reg_write(REG_DEPTH, dep);
  endtask

  task automatic send_item(bit cmd, bit [31:0] mn[3], bit [31:0] mx[3], bit [15:0] tag);
    in_valid <= 1;
    in_cmd <= cmd;
    in_object_tag <= tag;
    for (int a = 0; a < 3; a++) begin
      pmin[a] <= mn[a];
      pmax[a] <= mx[a];
    end
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_box(bit [31:0] lo, bit [31:0] hi);
    bit [31:0] mn[3], mx[3];
    for (int a = 0; a < 3; a++) begin
      mn[a] = lo;
      mx[a] = hi;
    end
    send_item(1'b1, mn, mx, 16'($urandom));
  endtask

  task automatic random_item(int unsigned clear_per_mille);
    bit [31:0] mn[3], mx[3], t;
    longint c, s, h;
    int unsigned kind;
    kind = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      h = longint'(sb.rhalf[a]);
      c = (longint'($urandom) % (2*h + 1)) - h;
      s = longint'($urandom >> $urandom_range(6, 31));
      mn[a] = 32'(sb.org[a] + c - s);
      mx[a] = 32'(sb.org[a] + c + s);
      if (kind >= 92) begin
        mn[a] = $urandom;
        mx[a] = $urandom;
      end else if (kind >= 85) begin
        t = mn[a];
        mn[a] = mx[a];
        mx[a] = t;
      end
    end
    send_item($urandom_range(999) >= clear_per_mille, mn, mx, 16'($urandom));
  endtask

  initial begin
    bit [31:0] z[3];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    z = '{0, 0, 0};
    // insert before any clear, then corner boxes
    send_box(32'h0000_1000, 32'h0000_2000);
    send_item(1'b0, z, z, 16'd0);
    send_box(32'h8000_0000, 32'h8000_0000);
    send_box(32'h7fff_ffff, 32'h7fff_ffff);
    send_box(32'h8000_0000, 32'h7fff_ffff);
    send_box(32'h0000_0000, 32'h0000_0000);
    send_box(32'hffff_ffff, 32'h0000_0000);
    send_box(32'hffff_fff0, 32'hffff_ffff);
    send_box(32'h0000_8000, 32'h0000_4000);
    send_box(32'h7fff_ffff, 32'h8000_0000);
    send_box(32'h0000_4000, 32'h0000_4001);
    send_box(32'h0000_4000, 32'h0000_4001);
    send_item(1'b1, '{32'h10, 32'hffff_0000, 32'h100}, '{32'h20, 32'hffff_0010, 32'h120},
              16'hffff);
    send_item(1'b0, z, z, 16'hffff);
    send_box(32'hffff_c000, 32'hffff_c100);
    for (int i = 0; i < 120; i++) random_item(25);

    tx_idle = 79;
    rx_idle = 27;
    configure(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 15);
    send_item(1'b0, z, z, 16'd0);
    for (int i = 0; i < 120; i++) random_item(25);

    tx_idle = 0;
    rx_idle = 0;
    configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    send_item(1'b0, z, z, 16'd0);
    for (int i = 0; i < 60; i++) random_item(25);

    configure($urandom_range(0, 32'h00ff_ffff), 32'hfff0_0000, 32'h0001_0000,
              32'h0010_0000, 32'h0000_0400, 32'h0100_0000, 15);
    send_item(1'b0, z, z, 16'd0);
    for (int i = 0; i < 1100; i++) random_item(0);
    in_valid <= 0;

    drain();
    if (errors == 0) $display("tb_octree_box_insert passed");
    else $display("tb_octree_box_insert failed");
    $finish;
  end
endmodule
